// ===== rtl/skm_pkg.sv =====
// Shared constants, register indexes and control structs of the multichannel
// scalar Kalman smoother. No dependencies; every other file of the block uses it.
`default_nettype none

package skm_pkg;

  // Field widths
  localparam int CW = 5;   // channel index
  localparam int SW = 16;  // sample
  localparam int EW = 32;  // estimate, signed Q16.16
  localparam int VW = 24;  // variance and noise registers, unsigned Q8.16
  localparam int KW = 17;  // gain, Q0.16 plus the bit that carries 1.0

  localparam int CHANNELS_DEF = 32;

  localparam logic [VW-1:0] Q_RESET = 24'd1442;
  localparam logic [VW-1:0] R_RESET = 24'd40436;
  localparam logic [VW-1:0] VAR_MAX = 24'hFFFFFF;

  // Configuration register indexes
  typedef enum logic {
    CFG_PROCESS_NOISE     = 1'b0,
    CFG_MEASUREMENT_NOISE = 1'b1
  } skm_cfg_idx_t;

  // One quotient bit a cycle, most significant first
  typedef struct packed {
    logic q_valid;
    logic q_bit;
    logic last;
  } skm_div_stat_t;

  // Drive of the shift-add accumulators
  typedef struct packed {
    logic clear;
    logic step;
    logic q_bit;
  } skm_mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/skm_store.sv =====
// Per-channel state memory: estimate and variance, one read and one write port.
// Runs a clearing pass after reset. Uses skm_pkg.
`default_nettype none

module skm_store #(
  parameter int CHANNELS = skm_pkg::CHANNELS_DEF,
  parameter int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output logic      [skm_pkg::EW-1:0]  rd_est,
  output logic      [skm_pkg::VW-1:0]  rd_var,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [skm_pkg::EW-1:0]  wr_est,
  input  wire logic [skm_pkg::VW-1:0]  wr_var,
  output logic                         ready
);

  logic [skm_pkg::EW-1:0] est_mem [CHANNELS];
  logic [skm_pkg::VW-1:0] var_mem [CHANNELS];
  logic [skm_pkg::EW-1:0] rd_est_r;
  logic [skm_pkg::VW-1:0] rd_var_r;
  logic                   clearing_r;
  logic [AW-1:0]          clr_addr_r;

  // sweep all entries to zero, one per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(CHANNELS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      est_mem[clr_addr_r] <= '0;
      var_mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      est_mem[wr_addr] <= wr_est;
      var_mem[wr_addr] <= wr_var;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_est_r <= est_mem[rd_addr];
      rd_var_r <= var_mem[rd_addr];
    end
  end

  assign rd_est = rd_est_r;
  assign rd_var = rd_var_r;
  assign ready  = !clearing_r;

endmodule

`default_nettype wire

// ===== rtl/skm_sdiv.sv =====
// Bit-serial restoring divider for the gain: floor(pp*65536/divisor), one
// quotient bit per cycle, most significant first. Uses skm_pkg.
`default_nettype none

module skm_sdiv (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [skm_pkg::VW-1:0]    pp,
  input  wire logic [skm_pkg::VW:0]      divisor,
  output skm_pkg::skm_div_stat_t         stat
);

  localparam int CNTW = $clog2(skm_pkg::KW);

  logic                   busy_r;
  logic [CNTW-1:0]        cnt_r;
  logic [skm_pkg::VW:0]   rem_r;
  logic                   nbit_r;
  logic [skm_pkg::VW:0]   div_r;
  logic [skm_pkg::VW+1:0] shifted;
  logic [skm_pkg::VW+1:0] trial;
  logic                   ge;
  logic                   last;

  assign shifted = {rem_r, nbit_r};
  assign trial   = shifted - {1'b0, div_r};
  assign ge      = shifted >= {1'b0, div_r};
  assign last    = cnt_r == CNTW'(skm_pkg::KW - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // dividend is pp followed by 16 zero bits; the partial remainder starts
  // at pp>>1 so that 17 steps cover the quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {2'b00, pp[skm_pkg::VW-1:1]};
      nbit_r <= pp[0];
      div_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= ge ? trial[skm_pkg::VW:0] : shifted[skm_pkg::VW:0];
      nbit_r <= 1'b0;
    end
  end

  assign stat.q_valid = busy_r;
  assign stat.q_bit   = ge && (div_r != '0);  // zero divisor gives zero gain
  assign stat.last    = last;

endmodule

`default_nettype wire

// ===== rtl/skm_smac.sv =====
// Shift-add accumulator fed one multiplier bit per cycle, most significant
// first: acc = 2*acc + bit*a. Uses skm_pkg.
`default_nettype none

module skm_smac #(
  parameter int WA = 33
) (
  input  wire logic                              clk,
  input  wire skm_pkg::skm_mac_ctl_t             ctl,
  input  wire logic signed [WA-1:0]              a,
  output logic signed [WA+skm_pkg::KW-1:0]       acc
);

  logic signed [WA+skm_pkg::KW-1:0] acc_r;
  logic signed [WA+skm_pkg::KW-1:0] a_ext;

  assign a_ext = {{skm_pkg::KW{a[WA-1]}}, a};

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.step) begin
      acc_r <= (acc_r <<< 1) + (ctl.q_bit ? a_ext : '0);
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== rtl/scalar_kalman_multichannel.sv =====
// Multichannel scalar Kalman smoother, top level: config registers, sequencer,
// output register. Instantiates skm_store, skm_sdiv and skm_smac; uses skm_pkg.
//
// Usage:
//   Input words carry a channel index and a signed 16-bit sample; each word
//   yields exactly one output word with the channel echoed and the new
//   estimate in signed Q16.16. Words are taken when tvalid and tready are high.
//   Process and measurement noise are written through cfg_* while idle.
// Sequence:
//   A channel that is unstarted (stored estimate zero) or out of range
//   passes ST_LOAD and then ST_FIN, which hands the result to the output
//   register and raises out_tvalid. A started channel passes ST_LOAD, ST_PREP,
//   ST_DIV and ST_FIN and runs a one-bit-per-cycle gain division in ST_DIV
//   with both products accumulated alongside it. in_tready is high only in
//   ST_IDLE, so a new word is taken only once ST_FIN has handed over the result.
// Reset:
//   rst_n is synchronous, active low. Noise registers return to their reset
//   values, and a clearing pass zeroes the state memory; in_tready stays low
//   during that pass.
// Stall:
//   The result waits in an output register; the next word is still accepted.
//   A result finishing while that register is full holds until it drains.
`default_nettype none

module scalar_kalman_multichannel #(
  parameter int CHANNELS = skm_pkg::CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input: [4:0] channel, [20:5] sample, [23:21] zero
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  // output: [4:0] out_channel, [36:5] estimate, [39:37] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [23:0] cfg_wr_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = skm_pkg::CW;
  localparam int SW = skm_pkg::SW;
  localparam int EW = skm_pkg::EW;
  localparam int VW = skm_pkg::VW;
  localparam int KW = skm_pkg::KW;
  localparam int DW = EW + 1;  // innovation width

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                state_r;
  logic [VW-1:0]         q_r;
  logic [VW-1:0]         r_r;
  logic [CW-1:0]         ch_r;
  logic signed [SW-1:0]  sample_r;
  logic                  in_range_r;
  logic                  started_r;
  logic [EW-1:0]         x_r;
  logic [VW-1:0]         var_r;
  logic [VW-1:0]         pp_r;
  logic signed [DW-1:0]  diff_r;
  logic                  out_valid_r;
  logic [CW-1:0]         out_ch_r;
  logic [EW-1:0]         out_est_r;

  logic [CW-1:0]         in_ch;
  logic [SW-1:0]         in_sample;
  logic                  in_fire;
  logic                  in_range;
  logic [AW+CW-1:0]      in_ch_ext;
  logic [AW+CW-1:0]      ch_ext;
  logic                  st_ready;
  logic [EW-1:0]         rd_est;
  logic [VW-1:0]         rd_var;
  logic                  mem_we;
  logic [EW-1:0]         wr_est;
  logic [VW-1:0]         wr_var;
  logic [VW:0]           pp_sum;
  logic [VW-1:0]         pp_sat;
  logic [VW:0]           divisor;
  logic [EW-1:0]         meas;
  logic signed [DW-1:0]  diff_nxt;
  logic                  fin_go;
  logic [EW-1:0]         res;
  logic [VW+15:0]        var_diff;
  logic [VW-1:0]         var_new;
  logic signed [VW:0]    pp_signed;
  logic signed [DW+KW-1:0] kx_acc;
  logic signed [VW+KW:0]   kp_acc;

  skm_pkg::skm_div_stat_t div_stat;
  skm_pkg::skm_mac_ctl_t  mac_ctl;

  assign in_ch     = in_tdata[CW-1:0];
  assign in_sample = in_tdata[CW+SW-1:CW];
  assign in_tready = (state_r == ST_IDLE) && st_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign in_range  = 32'(in_ch) < 32'(CHANNELS);
  assign in_ch_ext = {{AW{1'b0}}, in_ch};
  assign ch_ext    = {{AW{1'b0}}, ch_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= skm_pkg::Q_RESET;
      r_r <= skm_pkg::R_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        skm_pkg::CFG_PROCESS_NOISE:     q_r <= cfg_wr_data;
        skm_pkg::CFG_MEASUREMENT_NOISE: r_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  skm_store #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire && in_range),
    .rd_addr (in_ch_ext[AW-1:0]),
    .rd_est  (rd_est),
    .rd_var  (rd_var),
    .wr_en   (mem_we),
    .wr_addr (ch_ext[AW-1:0]),
    .wr_est  (wr_est),
    .wr_var  (wr_var),
    .ready   (st_ready)
  );

  // predicted variance, saturated at full scale
  assign pp_sum = {1'b0, rd_var} + {1'b0, q_r};
  assign pp_sat = pp_sum[VW] ? skm_pkg::VAR_MAX : pp_sum[VW-1:0];

  // measurement in Q16.16 and innovation
  assign meas     = {sample_r, 16'h0000};
  assign diff_nxt = {meas[EW-1], meas} - {x_r[EW-1], x_r};
  assign divisor  = {1'b0, pp_r} + {1'b0, r_r};

  skm_sdiv u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_PREP),
    .pp      (pp_r),
    .divisor (divisor),
    .stat    (div_stat)
  );

  // both products take the gain bits as the divider produces them
  assign mac_ctl.clear = (state_r == ST_PREP);
  assign mac_ctl.step  = div_stat.q_valid;
  assign mac_ctl.q_bit = div_stat.q_bit;
  assign pp_signed     = {1'b0, pp_r};

  skm_smac #(.WA (DW)) u_mac_x (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (diff_r),
    .acc (kx_acc)
  );

  skm_smac #(.WA (VW + 1)) u_mac_p (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (pp_signed),
    .acc (kp_acc)
  );

  // x + floor(K*diff/65536), wrapped to 32 bits
  assign res = started_r ? (x_r + kx_acc[EW+15:16]) : meas;
  // (65536-K)*pp >> 16 as (pp<<16 - K*pp) >> 16
  assign var_diff = {pp_r, 16'h0000} - kp_acc[VW+15:0];
  assign var_new  = var_diff[VW+15:16];

  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign mem_we = fin_go && in_range_r;
  assign wr_est = res;
  assign wr_var = started_r ? var_new : var_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_r <= (in_range_r && (rd_est != '0)) ? ST_PREP : ST_FIN;
        end
        ST_PREP: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.q_valid && div_stat.last) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r       <= in_ch;
      sample_r   <= in_sample;
      in_range_r <= in_range;
    end
    if (state_r == ST_LOAD) begin
      started_r <= in_range_r && (rd_est != '0);
      x_r       <= rd_est;
      var_r     <= rd_var;
      pp_r      <= pp_sat;
    end
    if (state_r == ST_PREP) begin
      diff_r <= diff_nxt;
    end
    if (fin_go) begin
      out_ch_r  <= ch_r;
      out_est_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_est_r, out_ch_r};

  // divider only runs while the sequencer waits on it
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.q_valid |-> state_r == ST_DIV)
    else $error("divider active outside division");

  // the last gain bit hands over to the finish step
  a_div_last_fin: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.q_valid && div_stat.last |=> state_r == ST_FIN)
    else $error("finish step missed after last gain bit");

  // a gain of at most one never grows the variance above its prediction
  a_var_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && started_r |-> var_new <= pp_r)
    else $error("updated variance above predicted variance");

  // state is written only when a result is handed to the output register
  a_we_fin: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> out_valid_r && (state_r == ST_IDLE))
    else $error("state write without a result");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for scalar_kalman_multichannel: streams channel/sample words,
// predicts every smoothed estimate and compares each output word against it.
// Depends on skm_pkg (widths, reset noise values, register indexes) and the RTL top.
`default_nettype none

module tb;
  import skm_pkg::*;

  // Run bounds. The slowest legal run is roughly 1400 words, plus sender gaps,
  // receiver stalls and one long hold; the limit is several times that.
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;    // comfortably above the latency of one word
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int NCH          = CHANNELS_DEF;
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_WORDS  = 265;

  typedef struct packed {
    logic [CW-1:0] channel;
    logic [EW-1:0] estimate;
  } est_word_t;

  typedef enum logic [1:0] {RX_READY, RX_COIN, RX_PATTERN} rx_mode_e;
  typedef enum logic {TX_STREAM, TX_BURSTY} tx_mode_e;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata    = '0;   // [4:0] channel, [20:5] sample, [23:21] zero
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [39:0]  out_tdata;          // [4:0] out_channel, [36:5] estimate, [39:37] zero
  logic         cfg_wr_en   = 1'b0;
  skm_cfg_idx_t cfg_addr    = CFG_PROCESS_NOISE;
  logic [23:0]  cfg_wr_data = '0;

  scalar_kalman_multichannel dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predictor copy of the filter state and the noise registers
  logic [EW-1:0] est_mem [NCH];
  logic [VW-1:0] var_mem [NCH];
  logic [VW-1:0] q_noise;
  logic [VW-1:0] r_noise;

  // Estimates still owed by the block, oldest first
  est_word_t est_due [$];
  int        bad_words = 0;

  // Sender and receiver pacing
  rx_mode_e    rx_mode    = RX_READY;
  tx_mode_e    tx_mode    = TX_STREAM;
  int          burst_left = 0;
  bit          tx_busy    = 1'b0;
  int          hold_seq   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  logic [15:0] rx_pat     = '1;
  logic [3:0]  rx_pos     = '0;

  // Random traffic shaping: a few busy channels and a signal level per channel
  logic [CW-1:0] hot_ch [4];
  int            level  [NCH];

  initial forever #1 clk = ~clk;

  // Watchdog: end the run if the block hangs
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < LIMIT_CYCLES) begin
      @(posedge clk);
      cyc++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: a long hold-off when requested, otherwise the current stall pattern
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen  <= hold_seq;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_READY: begin
          out_tready <= 1'b1;
        end
        RX_COIN: begin
          out_tready <= ($urandom_range(0, 2) != 0);
        end
        default: begin
          out_tready <= rx_pat[rx_pos];
          rx_pos     <= rx_pos + 4'd1;
          if (rx_pos == 4'hF) rx_pat <= 16'($urandom);
        end
      endcase
    end
  end

  // Output checker: compare each accepted word with the oldest expected estimate
  always @(posedge clk) begin : check_words
    est_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (est_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: channel %0d estimate %h",
                   out_tdata[4:0], out_tdata[36:5]);
      end else begin
        want = est_due.pop_front();
        if (want.channel !== out_tdata[4:0] || want.estimate !== out_tdata[36:5]) begin
          bad_words++;
          if (bad_words <= 10)
            $display("mismatch: expected channel %0d estimate %h, got channel %0d estimate %h",
                     want.channel, want.estimate, out_tdata[4:0], out_tdata[36:5]);
        end
      end
    end
  end

  // One filter step on the predictor state; returns the word the block must emit
  function automatic est_word_t kalman_update(input logic [CW-1:0] ch,
                                              input logic [SW-1:0] smp);
    logic [EW-1:0] meas;
    logic [EW-1:0] nxt;
    logic [VW:0]   pp_wide;
    logic [VW-1:0] pp;
    logic [63:0]   divisor;
    logic [63:0]   gain;
    logic [63:0]   var_next;
    longint        x;
    longint        diff;
    longint        delta;
    est_word_t     w;
    meas      = {smp, 16'h0000};
    w.channel = ch;
    if (est_mem[ch] == '0) begin
      // Unstarted channel: load the sample, leave the variance alone
      est_mem[ch] = meas;
      w.estimate  = meas;
    end else begin
      x       = $signed(est_mem[ch]);
      pp_wide = {1'b0, var_mem[ch]} + {1'b0, q_noise};
      pp      = pp_wide[VW] ? VAR_MAX : pp_wide[VW-1:0];
      divisor = 64'(pp) + 64'(r_noise);
      gain    = (divisor == 64'd0) ? 64'd0 : ((64'(pp) << 16) / divisor);
      if (gain > 64'd65536) gain = 64'd65536;
      diff     = longint'($signed(smp)) * 65536 - x;
      delta    = (longint'(gain) * diff) >>> 16;   // floor toward minus infinity
      nxt      = EW'(x + delta);
      var_next = ((64'd65536 - gain) * 64'(pp)) >> 16;
      est_mem[ch] = nxt;
      var_mem[ch] = var_next[VW-1:0];
      w.estimate  = nxt;
    end
    return w;
  endfunction

  // Lower valid once a burst or a phase is over
  task automatic end_burst();
    if (tx_busy) begin
      in_tvalid <= 1'b0;
      tx_busy = 1'b0;
    end
  endtask

  // Insert a random gap after a burst of random length
  task automatic pace();
    int gap;
    if (tx_mode == TX_BURSTY) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        end_burst();
        gap = $urandom_range(1, 30);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end
    end
  endtask

  // Offer one word, hold it until taken, then record the expected estimate
  task automatic send_word(input logic [CW-1:0] ch, input logic [SW-1:0] smp);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, smp, ch};
    tx_busy = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    est_due.push_back(kalman_update(ch, smp));
    pace();
  endtask

  // Write both noise registers once the block has drained
  task automatic set_noise(input logic [VW-1:0] q, input logic [VW-1:0] r);
    end_burst();
    while (est_due.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= CFG_PROCESS_NOISE;
    cfg_wr_data <= q;
    @(posedge clk);
    cfg_addr    <= CFG_MEASUREMENT_NOISE;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    q_noise = q;
    r_noise = r;
  endtask

  function automatic logic [CW-1:0] pick_channel();
    if ($urandom_range(0, 9) < 6) return hot_ch[$urandom_range(0, 3)];
    return CW'($urandom_range(0, NCH - 1));
  endfunction

  // Mostly a noisy level per channel, with extremes and wide jumps mixed in
  function automatic logic [SW-1:0] pick_sample(input logic [CW-1:0] ch);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        v = level[ch] + int'($urandom_range(0, 128)) - 64;
      end
      6: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: begin
        v = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SW'(v);
  endfunction

  task automatic shuffle_traffic();
    for (int i = 0; i < NCH; i++) level[i] = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < 4; i++) hot_ch[i] = CW'($urandom_range(0, NCH - 1));
  endtask

  // Reset noise: channel start-up, repeat samples, full-scale steps, zero samples
  // that keep a channel unstarted, top channel index
  task automatic test_startup();
    send_word(5'd0, 16'h7FFF);
    send_word(5'd0, 16'h7FFF);
    send_word(5'd0, 16'h8000);
    send_word(5'd0, 16'h0000);
    send_word(5'd31, 16'h8000);
    send_word(5'd31, 16'd100);
    send_word(5'd2, 16'h0000);
    send_word(5'd2, 16'h0000);
    send_word(5'd2, 16'hFFFF);
    send_word(5'd2, 16'h0001);
    send_word(5'd5, 16'h0001);
    send_word(5'd5, 16'hFFFF);
  endtask

  // Zero divisor gives zero gain; zero measurement noise gives full gain,
  // which drives an estimate back to zero and unstarts the channel
  task automatic test_gain_corners();
    set_noise('0, '0);
    send_word(5'd7, 16'd1000);
    send_word(5'd7, 16'd2000);
    set_noise(24'd16, '0);
    send_word(5'd7, 16'h0000);
    send_word(5'd7, 16'h0000);
    send_word(5'd7, 16'hFFFB);
  endtask

  // Largest process noise: the predicted variance saturates before the gain
  task automatic test_variance_saturation();
    set_noise(VAR_MAX, VAR_MAX);
    send_word(5'd9, 16'd300);
    send_word(5'd9, 16'hFED4);
    send_word(5'd9, 16'h7FFF);
    send_word(5'd9, 16'h8000);
    set_noise(VAR_MAX, '0);
    send_word(5'd10, 16'd10);
    send_word(5'd10, 16'hFFEC);
    send_word(5'd10, 16'h7FFF);
  endtask

  // Hold the receiver off for a long stretch while words keep coming,
  // so the output register fills and the block stalls its input
  task automatic test_backpressure();
    logic [CW-1:0] ch;
    set_noise(Q_RESET, R_RESET);
    shuffle_traffic();
    rx_mode = RX_READY;
    tx_mode = TX_STREAM;
    hold_seq <= hold_seq + 1;
    for (int n = 0; n < 30; n++) begin
      ch = pick_channel();
      send_word(ch, pick_sample(ch));
    end
  endtask

  // Random phases, each with its own noise setting and pacing
  task automatic test_random_traffic();
    logic [CW-1:0] ch;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_noise(VW'($urandom_range(0, 4096)), VW'($urandom_range(1, 1 << 20)));
        1: set_noise('0, VW'($urandom));
        2: set_noise(VAR_MAX, VAR_MAX);
        3: set_noise(VW'($urandom), '0);
        default: set_noise(VW'($urandom), VW'($urandom));
      endcase
      shuffle_traffic();
      if (ph == 0) begin
        // one stretch with no idling on either side
        rx_mode = RX_READY;
        tx_mode = TX_STREAM;
      end else begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        tx_mode = TX_BURSTY;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        ch = pick_channel();
        send_word(ch, pick_sample(ch));
      end
    end
  endtask

  initial begin
    q_noise = Q_RESET;
    r_noise = R_RESET;
    for (int i = 0; i < NCH; i++) begin
      est_mem[i] = '0;
      var_mem[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_startup();
    test_gain_corners();
    test_variance_saturation();
    test_backpressure();
    test_random_traffic();

    // Drain: wait for every owed word, then watch for strays
    end_burst();
    while (est_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_words == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
